[src/assert_macros.svh]
// assertion macros used by the checker file bse_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// two-signal form: when cond holds, expect must hold in the same cycle
`define BSE_ASSERT_IMP(label, clk, rst_n, cond, expect_v, msg) \
    `BSE_ASSERT(label, clk, rst_n, (cond) |-> (expect_v), msg)

`endif

[src/bse_pkg.sv]
// byte string escaper package: transfer types, character constants, hex helper
// no dependencies
package bse_pkg;

    localparam int CNT_W = 16;
    localparam int LEN_W = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_EXCL   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    localparam logic [CNT_W-1:0] CAP_RESET  = 16'd256;
    localparam logic [CNT_W:0]   HEAD_ROOM  = 17'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       out_char;
        logic             last_of_run;
        logic             is_terminator;
        logic [CNT_W-1:0] char_count;
    } t_out_item;

    typedef struct packed {
        logic [3:0][7:0]  chars;
        logic [LEN_W-1:0] len;
    } t_esc;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

endpackage

[src/bse_escape.sv]
// escape decoder: maps one raw byte to its escaped character sequence
// depends on bse_pkg
module bse_escape (
    input  logic [7:0]    i_byte,
    output bse_pkg::t_esc o_esc
);
    import bse_pkg::*;

    always_comb begin
        o_esc.chars = '0;
        o_esc.len   = 3'd1;
        case (i_byte)
            CH_TAB: begin
                o_esc.chars[0] = CH_BSLASH;
                o_esc.chars[1] = CH_LOW_T;
                o_esc.len      = 3'd2;
            end
            CH_LF: begin
                o_esc.chars[0] = CH_BSLASH;
                o_esc.chars[1] = CH_LOW_N;
                o_esc.len      = 3'd2;
            end
            CH_CR: begin
                o_esc.chars[0] = CH_BSLASH;
                o_esc.chars[1] = CH_LOW_R;
                o_esc.len      = 3'd2;
            end
            CH_EXCL, CH_DQUOTE, CH_DOLLAR, CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS,
            CH_DOT, CH_QMARK, CH_LBRACK, CH_BSLASH, CH_CARET, CH_LBRACE,
            CH_PIPE: begin
                o_esc.chars[0] = CH_BSLASH;
                o_esc.chars[1] = i_byte;
                o_esc.len      = 3'd2;
            end
            default: begin
                if (i_byte < CH_SPACE || i_byte >= CH_DEL) begin
                    // non-printable: hex form
                    o_esc.chars[0] = CH_BSLASH;
                    o_esc.chars[1] = CH_LOW_X;
                    o_esc.chars[2] = hex_digit(i_byte[7:4]);
                    o_esc.chars[3] = hex_digit(i_byte[3:0]);
                    o_esc.len      = 3'd4;
                end else begin
                    o_esc.chars[0] = i_byte;
                    o_esc.len      = 3'd1;
                end
            end
        endcase
    end

endmodule

[src/byte_string_escaper_core.sv]
// byte string escaper top level: combinational escape decode, expansion stage, output register
// depends on bse_pkg and bse_escape
// usage
//   input channel i_in_valid / o_in_ready carries one raw byte plus a last flag;
//   output channel o_out_valid / i_out_ready carries one escaped character per
//   transfer, then a NUL terminator item with the total count after a last byte
//   config: i_cfg_we writes i_cfg_wdata into the capacity register (reset 256),
//   write only while the block is idle
//   a byte is escaped only while count + 4 < capacity, otherwise it is dropped
// the first result item of a byte passes the expansion stage, then the output register
// throughput: one result item per cycle while the output is not stalled; a byte
//   occupies the expansion stage until its characters (1, 2 or 4, or none when
//   dropped) and, when it is last, the terminator have moved out one at a time
//   a dropped byte that is not last never enters the expansion stage
// the next byte is taken in the same cycle the previous byte's final item moves
//   to the output register, so bytes flow back to back
// reset: synchronous active low, clears the count, the stage and output valids,
//   capacity returns to 256
// stall: when i_out_ready is low the output item holds, the expansion stage
//   holds, and o_in_ready drops once the stage is occupied
module byte_string_escaper_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bse_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bse_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata
);
    import bse_pkg::*;

    // configuration and running count
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_used, n_used;

    // expansion stage: escaped chars of the byte in flight
    logic             r_stg_vld, n_stg_vld;
    logic [3:0][7:0]  r_buf;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_term;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] r_idx, n_idx;

    // output register
    logic             r_out_vld, n_out_vld;
    t_out_item        r_out;

    t_esc             esc;
    logic             in_xfer;
    logic             fits;
    logic             out_load;
    logic [LEN_W-1:0] total;
    logic             stg_final;
    t_out_item        cur_item;

    bse_escape u_esc (
        .i_byte (i_in_item.in_byte),
        .o_esc  (esc)
    );

    // room check against remaining space, widened so +4 cannot wrap
    assign fits = ({1'b0, r_used} + HEAD_ROOM) < {1'b0, r_cap};
    assign n_len = fits ? esc.len : '0;
    assign n_cnt = r_used + {{(CNT_W-LEN_W){1'b0}}, n_len};

    // item selection from the expansion stage
    assign total     = r_len + {{(LEN_W-1){1'b0}}, r_term};
    assign stg_final = (r_idx == total - 3'd1);
    assign out_load  = r_stg_vld && (!r_out_vld || i_out_ready);

    always_comb begin
        cur_item.last_of_run = stg_final;
        if (r_idx < r_len) begin
            cur_item.out_char      = r_buf[r_idx[1:0]];
            cur_item.is_terminator = 1'b0;
            cur_item.char_count    = '0;
        end else begin
            cur_item.out_char      = CH_NUL;
            cur_item.is_terminator = 1'b1;
            cur_item.char_count    = r_cnt;
        end
    end

    // stage frees up as its final item moves out
    assign o_in_ready = !r_stg_vld || (out_load && stg_final);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_used    = r_used;
        n_stg_vld = r_stg_vld;
        n_idx     = r_idx;
        n_out_vld = r_out_vld;
        if (out_load) begin
            n_out_vld = 1'b1;
            n_idx     = r_idx + 3'd1;
            if (stg_final) begin
                n_stg_vld = 1'b0;
            end
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (in_xfer) begin
            // dropped non-last byte makes no items and leaves the stage empty
            n_stg_vld = (n_len != '0) || i_in_item.last_byte;
            n_idx     = '0;
            n_used    = i_in_item.last_byte ? '0 : n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_used    <= '0;
            r_stg_vld <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_used    <= n_used;
            r_stg_vld <= n_stg_vld;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf  <= esc.chars;
            r_len  <= n_len;
            r_term <= i_in_item.last_byte;
            r_cnt  <= n_cnt;
        end
        if (out_load) begin
            r_out <= cur_item;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

[src/bse_checker.sv]
// port-level checker for the byte string escaper, bound to the top level
// depends on bse_pkg and assert_macros.svh
`include "assert_macros.svh"

module bse_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input bse_pkg::t_out_item o_out_item
);
    import bse_pkg::*;

    `BSE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)), "output item changed while stalled")
    `BSE_ASSERT_IMP(a_term_shape, i_clk, i_rst_n, o_out_valid && o_out_item.is_terminator, o_out_item.out_char == CH_NUL && o_out_item.last_of_run, "terminator not NUL or not last of run")
    `BSE_ASSERT_IMP(a_char_no_cnt, i_clk, i_rst_n, o_out_valid && !o_out_item.is_terminator, o_out_item.char_count == '0, "count on a non-terminator item")
    `BSE_ASSERT_IMP(a_char_not_nul, i_clk, i_rst_n, o_out_valid && !o_out_item.is_terminator, o_out_item.out_char != CH_NUL, "NUL character outside terminator")

endmodule

bind byte_string_escaper_core bse_checker u_bse_checker (.*);
